[hw/rtl/lzo_pkg.sv]
// Shared constants, types and codes of the LZO1X stream decompressor.
`timescale 1ns / 1ps
package lzo_pkg;

    localparam int HIST_DEPTH = 65536;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int BURST      = 64;
    localparam int CNT_W      = $clog2(BURST + 1);
    localparam int M3_SPAN    = 16384;

    // Status codes carried by every result.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DONE      = 3'd1;
    localparam logic [2:0] ST_IN_OVR    = 3'd2;
    localparam logic [2:0] ST_OUT_OVR   = 3'd3;
    localparam logic [2:0] ST_BREF_OVR  = 3'd4;
    localparam logic [2:0] ST_NOT_CONS  = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_OUT_LIMIT   = 1'b0;
    localparam logic CFG_CHECK_TRUNC = 1'b1;

    // Meaning of an instruction code below 16.
    localparam logic [1:0] LM_LIT = 2'd0;
    localparam logic [1:0] LM_M1S = 2'd1;
    localparam logic [1:0] LM_M1L = 2'd2;

    typedef enum logic [5:0] {
        PH_FIRST = 6'b000001,
        PH_INSN  = 6'b000010,
        PH_EXT   = 6'b000100,
        PH_DIST1 = 6'b001000,
        PH_DIST2 = 6'b010000,
        PH_LIT   = 6'b100000
    } phase_t;

    typedef enum logic [2:0] {
        K_LITRUN = 3'd0,
        K_M1S    = 3'd1,
        K_M1L    = 3'd2,
        K_M2     = 3'd3,
        K_M3     = 3'd4,
        K_M4     = 3'd5
    } kind_t;

    // One job per accepted transaction: a literal, a copy burst or nothing.
    typedef struct packed {
        logic               is_copy;
        logic               has_byte;
        logic [7:0]         lit;
        logic [CNT_W-1:0]   count;
        logic [HIST_AW-1:0] back_dist;
        logic [2:0]         status;
        logic               more;
        logic [31:0]        total;
    } job_t;

endpackage

[hw/rtl/lzo1x_stream_decompressor_core.sv]
// Top level of the LZO1X stream decompressor.
`timescale 1ns / 1ps
// Feed the compressed stream one byte per transaction (s_tuser 0) and mark the
// final byte with s_tlast; a transaction with s_tuser 1 drains a pending match.
// Every transaction yields one or more results, the last with m_tlast set; a
// match yields at most 64 bytes per transaction and m_tdata[11] asks for drains.
// The parser takes one transaction per cycle, while the two-entry job queue is
// not full. The output engine emits a literal or an empty result from its idle
// state; a copy burst fetches the job, then passes a read and a write state per
// copied byte, as the registered read of the 64 KiB history RAM must see the
// byte written just before it. Status and length in every result are the
// values after the whole transaction. Reset starts a new stream.
module lzo1x_stream_decompressor_core import lzo_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] req_type
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] out_byte, [10:8] status, [11] more_pending,
                                   // [43:12] total_length, [47:44] zero
    output logic        m_tuser,   // [0] byte_valid
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    logic q_full;
    logic q_push;
    job_t q_in;
    logic q_pop;
    logic q_valid;
    job_t q_head;

    lzo_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_in)
    );

    lzo_jobq u_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    lzo_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[hw/rtl/lzo_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lzo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/lzo_front.sv]
// Stream parser: takes compressed bytes, keeps all counts and emits one job per transaction.
`timescale 1ns / 1ps
module lzo_front import lzo_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        q_full,
    output logic        q_push,
    output job_t        q_job
);

    phase_t      phase_reg, phase_next;
    kind_t       kind_reg, kind_next;
    logic [7:0]  insn_reg, insn_next;
    logic [31:0] lacc_reg, lacc_next;
    logic [16:0] bdist_reg, bdist_next;
    logic [31:0] oc_reg, oc_next;
    logic [31:0] crem_reg, crem_next;
    logic [1:0]  trail_reg, trail_next;
    logic [2:0]  fin_reg, fin_next;
    logic [1:0]  low_reg, low_next;
    logic [1:0]  after_reg, after_next;
    logic [7:0]  dlow_reg, dlow_next;
    logic        fresh_reg, fresh_next;
    logic        ended_reg, ended_next;
    logic [31:0] limit_reg;
    logic        chk_reg;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [9:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {23'd0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    always_comb
    begin
        logic [7:0]       b;
        logic [7:0]       u;
        logic             tk;
        logic [1:0]       lm;
        logic             bl;
        logic [31:0]      bl_cnt;
        logic [1:0]       bl_mode;
        logic             do_match;
        logic             emit_lit;
        logic [CNT_W-1:0] burst;
        logic [4:0]       v;
        logic [15:0]      w;
        logic [16:0]      bd;

        b = s_tdata;
        u = insn_reg;
        tk = 1'b0;
        lm = low_reg;
        bl = 1'b0;
        bl_cnt = 32'd0;
        bl_mode = LM_LIT;
        do_match = 1'b0;
        emit_lit = 1'b0;
        burst = '0;
        v = 5'd0;
        w = 16'd0;
        bd = 17'd0;

        phase_next = phase_reg;
        kind_next  = kind_reg;
        insn_next  = insn_reg;
        lacc_next  = lacc_reg;
        bdist_next = bdist_reg;
        oc_next    = oc_reg;
        crem_next  = crem_reg;
        trail_next = trail_reg;
        fin_next   = fin_reg;
        low_next   = low_reg;
        after_next = after_reg;
        dlow_next  = dlow_reg;
        fresh_next = fresh_reg;
        ended_next = ended_reg;

        if (fin_reg == ST_OK)
        begin
            if (!s_tuser && crem_reg == 32'd0)
            begin
                unique case (phase_reg)
                    PH_FIRST:
                    begin
                        if (b > 8'd17)
                        begin
                            bl      = 1'b1;
                            bl_cnt  = {24'd0, b - 8'd17};
                            bl_mode = (b < 8'd21) ? LM_M1S : LM_M1L;
                        end
                        else
                        begin
                            low_next = LM_LIT;
                            lm       = LM_LIT;
                            tk       = 1'b1;
                        end
                    end
                    PH_INSN:
                    begin
                        tk = 1'b1;
                    end
                    PH_EXT:
                    begin
                        if (b == 8'd0)
                        begin
                            lacc_next = sat_add(lacc_reg, 10'd255);
                        end
                        else if (kind_reg == K_LITRUN)
                        begin
                            bl      = 1'b1;
                            bl_cnt  = sat_add(lacc_reg, {2'd0, b} + 10'd3);
                            bl_mode = LM_M1L;
                        end
                        else
                        begin
                            lacc_next  = sat_add(lacc_reg, {2'd0, b} + 10'd2);
                            phase_next = PH_DIST1;
                        end
                    end
                    PH_DIST1:
                    begin
                        if (kind_reg == K_M3 || kind_reg == K_M4)
                        begin
                            dlow_next  = b;
                            phase_next = PH_DIST2;
                        end
                        else
                        begin
                            trail_next = u[1:0];
                            if (kind_reg == K_M2)
                            begin
                                bd = {6'd0, b, u[4:2]} + 17'd1;
                            end
                            else if (kind_reg == K_M1S)
                            begin
                                bd = {7'd0, b, 2'd0} + {11'd0, u[7:2]} + 17'd1;
                            end
                            else
                            begin
                                bd = 17'd2049 + {7'd0, b, 2'd0} + {11'd0, u[7:2]};
                            end
                            bdist_next = bd;
                            do_match   = 1'b1;
                        end
                    end
                    PH_DIST2:
                    begin
                        w          = {b, dlow_reg};
                        trail_next = dlow_reg[1:0];
                        if (kind_reg == K_M3)
                        begin
                            bdist_next = {3'd0, w[15:2]} + 17'd1;
                            do_match   = 1'b1;
                        end
                        else
                        begin
                            bd = {2'd0, u[3], w[15:2]};
                            if (bd == 17'd0)
                            begin
                                bdist_next = bd;
                                fin_next = ended_reg ? ST_IN_OVR
                                         : (s_tlast ? ST_DONE : ST_NOT_CONS);
                            end
                            else
                            begin
                                bdist_next = bd + 17'(M3_SPAN);
                                do_match   = 1'b1;
                            end
                        end
                    end
                    PH_LIT:
                    begin
                        fresh_next = 1'b0;
                        if (fresh_reg && s_tlast && lacc_reg > 32'd1)
                        begin
                            fin_next = ST_IN_OVR;
                        end
                        else if (fresh_reg &&
                                 ({1'b0, oc_reg} + {1'b0, lacc_reg} > {1'b0, limit_reg}))
                        begin
                            fin_next = ST_OUT_OVR;
                        end
                        else
                        begin
                            emit_lit  = 1'b1;
                            oc_next   = oc_reg + 32'd1;
                            lacc_next = lacc_reg - 32'd1;
                            if (lacc_reg == 32'd1)
                            begin
                                low_next   = after_reg;
                                phase_next = PH_INSN;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_FIRST;
                    end
                endcase

                if (tk)
                begin
                    insn_next = b;
                    if (b >= 8'd64)
                    begin
                        kind_next  = K_M2;
                        lacc_next  = {29'd0, b[7:5]} + 32'd1;
                        phase_next = PH_DIST1;
                    end
                    else if (b >= 8'd32)
                    begin
                        kind_next = K_M3;
                        v = b[4:0];
                        if (v != 5'd0)
                        begin
                            lacc_next  = {27'd0, v} + 32'd2;
                            phase_next = PH_DIST1;
                        end
                        else
                        begin
                            lacc_next  = 32'd31;
                            phase_next = PH_EXT;
                        end
                    end
                    else if (b >= 8'd16)
                    begin
                        kind_next = K_M4;
                        v = {2'd0, b[2:0]};
                        if (v != 5'd0)
                        begin
                            lacc_next  = {27'd0, v} + 32'd2;
                            phase_next = PH_DIST1;
                        end
                        else
                        begin
                            lacc_next  = 32'd7;
                            phase_next = PH_EXT;
                        end
                    end
                    else if (lm == LM_LIT)
                    begin
                        kind_next = K_LITRUN;
                        if (b[3:0] != 4'd0)
                        begin
                            bl      = 1'b1;
                            bl_cnt  = {28'd0, b[3:0]} + 32'd3;
                            bl_mode = LM_M1L;
                        end
                        else
                        begin
                            lacc_next  = 32'd15;
                            phase_next = PH_EXT;
                        end
                    end
                    else
                    begin
                        kind_next  = (lm == LM_M1S) ? K_M1S : K_M1L;
                        lacc_next  = (lm == LM_M1S) ? 32'd2 : 32'd3;
                        phase_next = PH_DIST1;
                    end
                end

                if (do_match)
                begin
                    if ({15'd0, bdist_next} > oc_reg)
                    begin
                        fin_next = ST_BREF_OVR;
                    end
                    else if ({1'b0, oc_reg} + {1'b0, lacc_next} > {1'b0, limit_reg})
                    begin
                        fin_next = ST_OUT_OVR;
                    end
                    else
                    begin
                        crem_next = lacc_next;
                        if (trail_next != 2'd0)
                        begin
                            bl      = 1'b1;
                            bl_cnt  = {30'd0, trail_next};
                            bl_mode = LM_M1S;
                        end
                        else
                        begin
                            low_next   = LM_LIT;
                            phase_next = PH_INSN;
                        end
                    end
                end

                if (bl)
                begin
                    lacc_next  = bl_cnt;
                    after_next = bl_mode;
                    fresh_next = 1'b1;
                    phase_next = PH_LIT;
                end

                if (s_tlast)
                begin
                    ended_next = 1'b1;
                end
            end

            if (fin_next == ST_OK)
            begin
                burst     = (crem_next > 32'(BURST)) ? CNT_W'(BURST) : crem_next[CNT_W-1:0];
                crem_next = crem_next - {{(32-CNT_W){1'b0}}, burst};
                oc_next   = oc_next + {{(32-CNT_W){1'b0}}, burst};
                if (ended_next && crem_next == 32'd0 &&
                    (phase_next == PH_EXT || phase_next == PH_LIT || chk_reg))
                begin
                    fin_next = ST_IN_OVR;
                end
            end
        end

        q_job.is_copy   = (burst != '0);
        q_job.has_byte  = emit_lit;
        q_job.lit       = b;
        q_job.count     = burst;
        q_job.back_dist = bdist_next[HIST_AW-1:0];
        q_job.status    = fin_next;
        q_job.more      = (crem_next != 32'd0);
        q_job.total     = oc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            kind_reg  <= K_LITRUN;
            insn_reg  <= 8'd0;
            lacc_reg  <= 32'd0;
            bdist_reg <= 17'd0;
            oc_reg    <= 32'd0;
            crem_reg  <= 32'd0;
            trail_reg <= 2'd0;
            fin_reg   <= ST_OK;
            low_reg   <= LM_LIT;
            after_reg <= LM_LIT;
            dlow_reg  <= 8'd0;
            fresh_reg <= 1'b0;
            ended_reg <= 1'b0;
            limit_reg <= 32'd0;
            chk_reg   <= 1'b1;
        end
        else
        begin
            if (q_push)
            begin
                phase_reg <= phase_next;
                kind_reg  <= kind_next;
                insn_reg  <= insn_next;
                lacc_reg  <= lacc_next;
                bdist_reg <= bdist_next;
                oc_reg    <= oc_next;
                crem_reg  <= crem_next;
                trail_reg <= trail_next;
                fin_reg   <= fin_next;
                low_reg   <= low_next;
                after_reg <= after_next;
                dlow_reg  <= dlow_next;
                fresh_reg <= fresh_next;
                ended_reg <= ended_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_OUT_LIMIT:   limit_reg <= cfg_data;
                    CFG_CHECK_TRUNC: chk_reg   <= cfg_data[0];
                    default:         limit_reg <= limit_reg;
                endcase
            end
        end
    end

endmodule

[hw/rtl/lzo_jobq.sv]
// Two-entry job queue between the parser and the output engine.
`timescale 1ns / 1ps
module lzo_jobq import lzo_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output job_t head
);

    job_t       slot_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

[hw/rtl/lzo_back.sv]
// Output engine: writes literals into history, replays match copies, drives results.
`timescale 1ns / 1ps
module lzo_back import lzo_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  job_t        q_head,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    output logic        m_tuser,
    output logic        m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RD   = 3'b010,
        S_WR   = 3'b100
    } bstate_t;

    bstate_t            st_reg, st_next;
    job_t               job_reg;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [HIST_AW-1:0] wp_reg, wp_next;
    logic               mv_reg, mv_next;
    logic [7:0]         ob_reg;
    logic               obv_reg;
    logic               ol_reg;
    logic [2:0]         ost_reg;
    logic               omore_reg;
    logic [31:0]        otot_reg;
    logic               load;
    logic [7:0]         ld_byte;
    logic               ld_valid;
    logic               ld_last;
    job_t               ld_job;
    logic               ram_we;
    logic [7:0]         ram_wdata;
    logic               ram_re;
    logic [HIST_AW-1:0] ram_raddr;
    logic [7:0]         ram_rdata;
    logic               out_free;

    assign out_free = !mv_reg || m_tready;

    always_comb
    begin
        st_next   = st_reg;
        rem_next  = rem_reg;
        wp_next   = wp_reg;
        mv_next   = mv_reg && !m_tready;
        q_pop     = 1'b0;
        load      = 1'b0;
        ld_byte   = 8'd0;
        ld_valid  = 1'b0;
        ld_last   = 1'b1;
        ld_job    = q_head;
        ram_we    = 1'b0;
        ram_wdata = q_head.lit;
        ram_re    = 1'b0;
        ram_raddr = wp_reg - job_reg.back_dist;

        unique case (st_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    if (q_head.is_copy)
                    begin
                        rem_next = q_head.count;
                        st_next  = S_RD;
                    end
                    else
                    begin
                        load     = 1'b1;
                        ld_valid = q_head.has_byte;
                        ld_byte  = q_head.has_byte ? q_head.lit : 8'd0;
                        if (q_head.has_byte)
                        begin
                            ram_we  = 1'b1;
                            wp_next = wp_reg + HIST_AW'(1);
                        end
                    end
                end
            end
            S_RD:
            begin
                ram_re  = 1'b1;
                st_next = S_WR;
            end
            S_WR:
            begin
                if (out_free)
                begin
                    load      = 1'b1;
                    ld_job    = job_reg;
                    ld_valid  = 1'b1;
                    ld_byte   = ram_rdata;
                    ld_last   = (rem_reg == CNT_W'(1));
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    wp_next   = wp_reg + HIST_AW'(1);
                    rem_next  = rem_reg - CNT_W'(1);
                    st_next   = (rem_reg == CNT_W'(1)) ? S_IDLE : S_RD;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase

        if (load)
        begin
            mv_next = 1'b1;
        end
    end

    lzo_ram #(
        .WIDTH (8),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_head;
        end
        if (load)
        begin
            ob_reg    <= ld_byte;
            obv_reg   <= ld_valid;
            ol_reg    <= ld_last;
            ost_reg   <= ld_job.status;
            omore_reg <= ld_job.more;
            otot_reg  <= ld_job.total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_IDLE;
            rem_reg <= '0;
            wp_reg  <= '0;
            mv_reg  <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            rem_reg <= rem_next;
            wp_reg  <= wp_next;
            mv_reg  <= mv_next;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {4'd0, otot_reg, omore_reg, ost_reg, ob_reg};
    assign m_tuser  = obv_reg;
    assign m_tlast  = ol_reg;

endmodule

[hw/rtl/lzo_props.sv]
// Port-level assertions for the decompressor core and their bind.
`timescale 1ns / 1ps
module lzo_props (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // A result without a byte is the only result of its transaction and reads zero.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast && m_tdata[7:0] == 8'd0)
        else $error("empty result malformed");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[10:8] <= 3'd5)
        else $error("status code out of range");

    // A stream only finishes once no copy bytes are left.
    a_fin_nomore: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[10:8] != 3'd0 |-> !m_tdata[11])
        else $error("finished with copy bytes pending");

    // Results of one transaction share its final length.
    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> !m_tvalid ||
            m_tdata[43:12] == $past(m_tdata[43:12]))
        else $error("length changed inside a transaction");

endmodule

bind lzo1x_stream_decompressor_core lzo_props u_props (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
